/* hw/rtl/inr_pkg.sv */
`default_nettype none
package inr_pkg;

  localparam int WORD_BITS = 64;
  localparam int ROOT_BITS = (WORD_BITS + 1) / 2;
  localparam int BIT_W     = $clog2(ROOT_BITS);
  localparam int MUL_W     = 2 * ROOT_BITS;
  localparam int PROD_W    = 3 * ROOT_BITS;
  localparam int VALUE_W   = 64;
  localparam int DEG_W     = 8;
  localparam int RESULT_W  = 64;
  localparam int IN_W      = ((VALUE_W + DEG_W + 7) / 8) * 8;
  localparam int OUT_W     = ((RESULT_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_BIT_START,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_CHECK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic init;
    logic start_bit;
    logic mul_lo;
    logic mul_hi;
    logic step_ok;
    logic keep_bit;
    logic next_bit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic trivial;
    logic over;
    logic cnt_last;
    logic bit_zero;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

/* hw/rtl/inr_ctrl.sv */
`default_nettype none
module inr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire inr_pkg::status_t sts,
  output inr_pkg::cmd_t         cmd
);
  import inr_pkg::*;

  state_t state;
  state_t state_next;
  logic   resolved;

  assign resolved = sts.over || sts.cnt_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        state_next = sts.trivial ? ST_FINISH : ST_BIT_START;
      end
      ST_BIT_START: state_next = ST_MUL_LO;
      ST_MUL_LO:    state_next = ST_MUL_HI;
      ST_MUL_HI:    state_next = ST_CHECK;
      ST_CHECK: begin
        if (resolved) begin
          state_next = sts.bit_zero ? ST_FINISH : ST_BIT_START;
        end else begin
          state_next = ST_MUL_LO;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_SETUP:     cmd.init = 1'b1;
      ST_BIT_START: cmd.start_bit = 1'b1;
      ST_MUL_LO:    cmd.mul_lo = 1'b1;
      ST_MUL_HI:    cmd.mul_hi = 1'b1;
      ST_CHECK: begin
        cmd.step_ok  = !sts.over;
        cmd.keep_bit = !sts.over && sts.cnt_last;
        cmd.next_bit = resolved && !sts.bit_zero;
      end
      ST_FINISH:    cmd.out_load = sts.out_free;
      default: begin
        cmd      = '0;
        s_tready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/inr_datapath.sv */
`default_nettype none
module inr_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [inr_pkg::IN_W-1:0]   s_tdata,
  input  wire inr_pkg::cmd_t              cmd,
  output inr_pkg::status_t                sts,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [inr_pkg::OUT_W-1:0]       m_tdata
);
  import inr_pkg::*;

  logic [WORD_BITS-1:0] v;
  logic [DEG_W-1:0]     deg;
  logic [ROOT_BITS-1:0] r;
  logic [BIT_W-1:0]     bitidx;
  logic [WORD_BITS-1:0] acc;
  logic [DEG_W-1:0]     cnt;
  logic [MUL_W-1:0]     plo;
  logic [MUL_W-1:0]     phi;

  logic [ROOT_BITS-1:0] cand;
  logic [ROOT_BITS-1:0] mul_a;
  logic [MUL_W-1:0]     mprod;
  logic [PROD_W-1:0]    prod;
  logic                 trivial;
  logic [RESULT_W-1:0]  triv_val;

  assign cand  = r | (ROOT_BITS'(1) << bitidx);
  assign mul_a = cmd.mul_hi ? ROOT_BITS'(acc[WORD_BITS-1:ROOT_BITS])
                            : acc[ROOT_BITS-1:0];
  assign mprod = MUL_W'(mul_a) * MUL_W'(cand);
  assign prod  = {phi, ROOT_BITS'(0)} + PROD_W'(plo);

  assign trivial = (v == '0) || (deg <= DEG_W'(1)) || (deg >= DEG_W'(WORD_BITS));

  always_comb begin
    if (v == '0 || deg == '0) begin
      triv_val = '0;
    end else if (deg == DEG_W'(1)) begin
      triv_val = RESULT_W'(v);
    end else begin
      triv_val = RESULT_W'(1);
    end
  end

  assign sts.trivial  = trivial;
  assign sts.over     = prod > PROD_W'(v);
  assign sts.cnt_last = cnt == DEG_W'(1);
  assign sts.bit_zero = bitidx == '0;
  assign sts.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v   <= s_tdata[WORD_BITS-1:0];
      deg <= s_tdata[VALUE_W +: DEG_W];
    end
    if (cmd.init) begin
      r      <= '0;
      bitidx <= BIT_W'(ROOT_BITS - 1);
    end
    if (cmd.start_bit) begin
      acc <= WORD_BITS'(1);
      cnt <= deg;
    end
    if (cmd.mul_lo) plo <= mprod;
    if (cmd.mul_hi) phi <= mprod;
    if (cmd.step_ok) begin
      acc <= prod[WORD_BITS-1:0];
      cnt <= cnt - DEG_W'(1);
    end
    if (cmd.keep_bit) r <= cand;
    if (cmd.next_bit) bitidx <= bitidx - BIT_W'(1);
    if (cmd.out_load) m_tdata <= trivial ? OUT_W'(triv_val) : OUT_W'(r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/integer_nth_root.sv */
// Zero value, degree 0, degree 1 or degree >= 64 take a short path; otherwise each of
// the 32 result bits is tried with k <= degree multiplies before the candidate bit is
// kept or dropped (one shared 32x32 multiplier, two passes per 64x32 product, then an
// add-and-compare step).
// Throughput: one transaction at a time; the next is taken once the result is queued.
// Reset: synchronous, active high; clears the controller and the output valid.
`default_nettype none
module integer_nth_root (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [inr_pkg::IN_W-1:0] s_tdata,  // value[63:0], root_degree[71:64]
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logic [inr_pkg::OUT_W-1:0]     m_tdata   // root_result[63:0]
);
  import inr_pkg::*;

  cmd_t    cmd;
  status_t sts;

  inr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  inr_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  a_lo_then_hi: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_lo |=> cmd.mul_hi) else $error("high partial product did not follow low");

  a_hi_then_check: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_hi |=> (cmd.step_ok || cmd.next_bit || !s_tready))
    else $error("compare did not follow high partial product");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready) else $error("second transaction taken while busy");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready)) else $error("result overwrote pending output");

endmodule
`default_nettype wire
